### rtl/bpbl_pkg.sv
// Shared constants, types and the double-dabble step for the BCD converter.
`timescale 1ns / 1ps
package bpbl_pkg;
  localparam int MAX_DIGITS  = 20;
  localparam int VALUE_W     = 64;
  localparam int COUNT_W     = 5;
  localparam int BCD_DIGITS  = 20;
  localparam int BCD_W       = BCD_DIGITS * 4;
  localparam int STEPS_PER_STAGE = 8;
  localparam int NUM_STAGES  = VALUE_W / STEPS_PER_STAGE;
  localparam int BYTE_IDX_W  = 4;

  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
    logic [COUNT_W-1:0] cnt;
  } bpbl_work_t;

  // one shift-add-3 step: fix up every digit, then shift the binary in
  function automatic bpbl_work_t dabble_step(input bpbl_work_t w);
    bpbl_work_t r;
    logic [3:0] dig;
    r = w;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      dig = w.bcd[d*4 +: 4];
      if (dig >= 4'd5) begin
        r.bcd[d*4 +: 4] = dig + 4'd3;
      end
    end
    {r.bcd, r.bin} = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
    return r;
  endfunction
endpackage

### rtl/bpbl_if.sv
// Request channel interfaces for input items and output bytes.
`timescale 1ns / 1ps
interface bpbl_in_if;
  logic                       valid;
  logic                       ready;
  logic [bpbl_pkg::VALUE_W-1:0] value;
  logic [bpbl_pkg::COUNT_W-1:0] digit_count;
  modport source (output valid, output value, output digit_count, input ready);
  modport sink   (input valid, input value, input digit_count, output ready);
endinterface

interface bpbl_out_if;
  logic                            valid;
  logic                            ready;
  logic [7:0]                      bcd_byte;
  logic [bpbl_pkg::BYTE_IDX_W-1:0] byte_index;
  logic                            last;
  logic                            overflow;
  modport source (output valid, output bcd_byte, output byte_index, output last,
                  output overflow, input ready);
  modport sink   (input valid, input bcd_byte, input byte_index, input last,
                  input overflow, output ready);
endinterface

### rtl/bpbl_stage.sv
// One pipeline stage: eight double-dabble steps between registers.
`timescale 1ns / 1ps
module bpbl_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  bpbl_pkg::bpbl_work_t up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output bpbl_pkg::bpbl_work_t dn_data
);
  import bpbl_pkg::*;

  logic       valid_r;
  bpbl_work_t data_r;
  bpbl_work_t data_nxt;

  always_comb begin
    data_nxt = up_data;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      data_nxt = dabble_step(data_nxt);
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end
endmodule

### rtl/bpbl_serializer.sv
// Emits the converted digits as packed BCD bytes, low byte first.
`timescale 1ns / 1ps
module bpbl_serializer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  bpbl_pkg::bpbl_work_t up_data,
  bpbl_out_if.source           out_ch
);
  import bpbl_pkg::*;

  logic                  busy_r;
  logic [BCD_W-1:0]      digits_r;
  logic [BYTE_IDX_W-1:0] idx_r;
  logic [BYTE_IDX_W-1:0] last_idx_r;
  logic                  odd_r;
  logic                  ovf_r;
  logic                  is_last;
  logic                  load;
  logic [BCD_DIGITS-1:0] nz;
  logic [BCD_DIGITS-1:0] nz_hi;
  logic [COUNT_W-1:0]    cnt_m1;

  always_comb begin
    for (int d = 0; d < BCD_DIGITS; d++) begin
      nz[d] = |up_data.bcd[d*4 +: 4];
    end
  end
  assign nz_hi  = nz >> up_data.cnt;
  assign cnt_m1 = up_data.cnt - COUNT_W'(1);

  assign is_last  = (idx_r == last_idx_r);
  assign up_ready = !busy_r || (out_ch.ready && is_last);
  assign load     = up_ready && up_valid;

  assign out_ch.valid      = busy_r;
  assign out_ch.bcd_byte   = {(is_last && odd_r) ? 4'h0 : digits_r[7:4], digits_r[3:0]};
  assign out_ch.byte_index = idx_r;
  assign out_ch.last       = is_last;
  assign out_ch.overflow   = is_last && ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (up_ready) begin
      busy_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digits_r   <= up_data.bcd;
      idx_r      <= '0;
      last_idx_r <= BYTE_IDX_W'(cnt_m1 >> 1);
      odd_r      <= up_data.cnt[0];
      ovf_r      <= |nz_hi;
    end else if (busy_r && out_ch.ready && !is_last) begin
      digits_r <= digits_r >> 8;
      idx_r    <= idx_r + BYTE_IDX_W'(1);
    end
  end

`ifndef SYNTHESIS
  a_ovf_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.overflow |-> out_ch.last)
    else $error("overflow on a byte that is not last");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= last_idx_r)
    else $error("byte index past last byte");
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && out_ch.ready && !is_last |=> busy_r && idx_r == $past(idx_r) + 4'd1)
    else $error("serializer did not advance");
  a_no_early_take: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !is_last |-> !up_ready)
    else $error("new request taken mid conversion");
`endif
endmodule

### rtl/binary_to_packed_bcd_lsb_first_core.sv
// Top level: 64-bit binary to packed BCD converter, low byte first.
// Each request carries a 64-bit value and a digit count (0 reads as 1, above 20 as 20) and
// returns ceil(count/2) bytes. The conversion runs through an eight-stage double-dabble
// pipeline, eight shift-add-3 steps per stage, with a register after each stage, and the
// byte serializer at the end registers the digits before the first byte is offered. The
// serializer sets the rate: one byte per cycle while the output is ready. It takes the next
// request as its last byte is taken, and requests queue in the pipeline.
`timescale 1ns / 1ps
module binary_to_packed_bcd_lsb_first_core (
  input  logic       clk,
  input  logic       rst_n,
  bpbl_in_if.sink    in_ch,
  bpbl_out_if.source out_ch
);
  import bpbl_pkg::*;

  logic       vld [NUM_STAGES+1];
  logic       rdy [NUM_STAGES+1];
  bpbl_work_t dat [NUM_STAGES+1];
  logic [COUNT_W-1:0] cnt_sat;

  always_comb begin
    priority if (in_ch.digit_count == '0) begin
      cnt_sat = COUNT_W'(1);
    end else if (in_ch.digit_count > COUNT_W'(MAX_DIGITS)) begin
      cnt_sat = COUNT_W'(MAX_DIGITS);
    end else begin
      cnt_sat = in_ch.digit_count;
    end
  end

  assign vld[0]     = in_ch.valid;
  assign in_ch.ready = rdy[0];
  assign dat[0]     = '{bcd: '0, bin: in_ch.value, cnt: cnt_sat};

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    bpbl_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[g]),
      .up_ready (rdy[g]),
      .up_data  (dat[g]),
      .dn_valid (vld[g+1]),
      .dn_ready (rdy[g+1]),
      .dn_data  (dat[g+1])
    );
  end

  bpbl_serializer u_ser (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (vld[NUM_STAGES]),
    .up_ready (rdy[NUM_STAGES]),
    .up_data  (dat[NUM_STAGES]),
    .out_ch   (out_ch)
  );
endmodule
